// ===== sv/iwc_pkg.sv =====
// Shared types, codes and helper functions of the identifier word classifier.
// No dependencies; imported by iwc_ctrl, iwc_dp and identifier_word_classifier.
package iwc_pkg;

	// input transaction kinds, carried in s_tuser
	localparam logic [1:0] MODE_WORD  = 2'd0;
	localparam logic [1:0] MODE_LOAD  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// load result status codes
	localparam logic [1:0] LOAD_OK       = 2'd0;
	localparam logic [1:0] LOAD_TOO_LONG = 2'd1;
	localparam logic [1:0] LOAD_FULL     = 2'd2;

	// word classes
	typedef enum logic [2:0] {
		CLS_VARIABLE = 3'd0,
		CLS_KEYWORD  = 3'd1,
		CLS_RESERVED = 3'd2,
		CLS_TYPE     = 3'd3,
		CLS_CONSTANT = 3'd4,
		CLS_BAD      = 3'd5
	} word_class_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_PROBE,
		ST_FETCH,
		ST_CHECK
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic search_init;
		logic probe;
		logic fetch;
		logic step;
		logic narrow_hi;
		logic narrow_lo;
		logic finish;
		logic match;
	} ctrl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic word_last;
		logic out_free;
		logic need_search;
		logic byte_go;
		logic byte_eq;
		logic byte_lt;
		logic at_low;
	} dp_sts_t;

	function automatic logic lower_char(input logic [7:0] ch);
		return (ch >= 8'h61) && (ch <= 8'h7a);
	endfunction

	function automatic logic upper_char(input logic [7:0] ch);
		return (ch >= 8'h41) && (ch <= 8'h5a);
	endfunction

	// class from case flags and table lookup outcome
	function automatic word_class_t classify(input logic first_lower, input logic first_upper,
			input logic upper_after, input logic lower_after, input logic match);
		word_class_t cls;
		if (first_lower) begin
			if (match)
				cls = CLS_KEYWORD;
			else
				cls = upper_after ? CLS_BAD : CLS_VARIABLE;
		end else if (first_upper && match) begin
			cls = CLS_RESERVED;
		end else if (lower_after) begin
			cls = upper_after ? CLS_BAD : CLS_CONSTANT;
		end else begin
			cls = CLS_TYPE;
		end
		return cls;
	endfunction

endpackage

// ===== sv/iwc_ctrl.sv =====
// Controller state machine of the identifier word classifier: input handshake
// and sequencing of the bisection search. Depends on iwc_pkg.
module iwc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  iwc_pkg::dp_sts_t   sts,
	output iwc_pkg::ctrl_cmd_t cmd
);
	import iwc_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && sts.out_free && sts.word_last)
					state_d = ST_CLASSIFY;
			end
			ST_CLASSIFY: begin
				state_d = sts.need_search ? ST_PROBE : ST_IDLE;
			end
			ST_PROBE: begin
				state_d = ST_FETCH;
			end
			ST_FETCH: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				priority if (sts.byte_go)
					state_d = ST_FETCH;
				else if (sts.byte_eq || sts.at_low)
					state_d = ST_IDLE;
				else
					state_d = ST_PROBE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready   = sts.out_free;
				cmd.accept = s_tvalid && sts.out_free;
			end
			ST_CLASSIFY: begin
				cmd.search_init = sts.need_search;
				cmd.finish      = !sts.need_search;
			end
			ST_PROBE: begin
				cmd.probe = 1'b1;
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
			end
			ST_CHECK: begin
				priority if (sts.byte_go) begin
					cmd.step = 1'b1;
				end else if (sts.byte_eq) begin
					cmd.finish = 1'b1;
					cmd.match  = 1'b1;
				end else if (sts.at_low) begin
					cmd.finish = 1'b1;
				end else if (sts.byte_lt) begin
					cmd.narrow_hi = 1'b1;
				end else begin
					cmd.narrow_lo = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== sv/iwc_dp.sv =====
// Datapath of the identifier word classifier: keyword memories, word buffer,
// case flags, bisection bounds, byte comparator and output register. Depends on iwc_pkg.
module iwc_dp #(
	parameter int KEYWORDS = 64,
	parameter int KEY_LEN  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  iwc_pkg::ctrl_cmd_t cmd,
	output iwc_pkg::dp_sts_t   sts,
	input  logic [7:0]         s_tdata,   // char_in
	input  logic               s_tlast,   // last
	input  logic [1:0]         s_tuser,   // mode
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,   // word_class[2:0], load_status[4:3], zero fill
	output logic               m_tuser    // from_load
);
	import iwc_pkg::*;

	localparam int STORE_DEPTH = KEYWORDS * KEY_LEN;
	localparam int AW     = $clog2(STORE_DEPTH);
	localparam int SLOT_W = (KEYWORDS > 1) ? $clog2(KEYWORDS) : 1;
	localparam int CNT_W  = $clog2(KEYWORDS + 1);
	localparam int LEN_W  = $clog2(KEY_LEN + 1);
	localparam int POS_W  = $clog2(KEY_LEN + 2);
	localparam int BIDX_W = $clog2(KEY_LEN);

	// memories
	logic [7:0]       store_mem [STORE_DEPTH];
	logic [LEN_W-1:0] len_mem   [KEYWORDS];
	logic [7:0]       wbuf_mem  [KEY_LEN];

	// control state
	logic [CNT_W-1:0] count_q;
	logic [POS_W-1:0] load_pos_q;
	logic [POS_W-1:0] word_len_q;
	logic             first_lower_q;
	logic             first_upper_q;
	logic             upper_after_q;
	logic             lower_after_q;
	logic             out_valid_q;

	// payload registers
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic [CNT_W-1:0] probe_q;
	logic [LEN_W-1:0] idx_q;
	logic [LEN_W-1:0] len_rd_q;
	logic [7:0]       key_rd_q;
	logic [7:0]       word_rd_q;
	word_class_t      out_class_q;
	logic [1:0]       out_status_q;
	logic             out_load_q;

	logic             acc_word;
	logic             acc_load;
	logic             acc_clear;
	logic             table_full;
	logic             key_too_long;
	logic [CNT_W:0]   mid_sum;
	logic [CNT_W-1:0] mid;
	logic [AW-1:0]    load_addr;
	logic [AW-1:0]    probe_addr;
	logic [7:0]       key_byte;
	logic [7:0]       word_byte;
	logic             load_done;
	logic             load_stored;
	logic [1:0]       load_status;

	// input decode
	assign acc_word  = cmd.accept && (s_tuser == MODE_WORD);
	assign acc_load  = cmd.accept && (s_tuser == MODE_LOAD);
	assign acc_clear = cmd.accept && (s_tuser == MODE_CLEAR);

	// load bookkeeping
	assign table_full   = (count_q == CNT_W'(KEYWORDS));
	assign key_too_long = (load_pos_q >= POS_W'(KEY_LEN));
	assign load_done    = acc_load && s_tlast;
	assign load_stored  = load_done && !key_too_long && !table_full;
	assign load_addr    = AW'(count_q[SLOT_W-1:0]) * AW'(KEY_LEN) + AW'(load_pos_q);

	always_comb begin
		priority if (key_too_long)
			load_status = LOAD_TOO_LONG;
		else if (table_full)
			load_status = LOAD_FULL;
		else
			load_status = LOAD_OK;
	end

	// bisection midpoint and byte address
	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid        = mid_sum[CNT_W:1];
	assign probe_addr = AW'(probe_q[SLOT_W-1:0]) * AW'(KEY_LEN) + AW'(idx_q);

	// byte comparison, ends of keyword and word read as zero
	assign key_byte  = (idx_q < len_rd_q) ? key_rd_q : 8'd0;
	assign word_byte = (POS_W'(idx_q) < word_len_q) ? word_rd_q : 8'd0;

	// status to controller
	always_comb begin
		sts.word_last   = (s_tuser == MODE_WORD) && s_tlast;
		sts.out_free    = !out_valid_q || m_tready;
		sts.need_search = (first_lower_q || first_upper_q) && (count_q != '0)
			&& (word_len_q <= POS_W'(KEY_LEN));
		sts.byte_eq     = (word_byte == key_byte);
		sts.byte_go     = (key_byte != 8'd0) && (word_byte == key_byte);
		sts.byte_lt     = (word_byte < key_byte);
		sts.at_low      = (probe_q == lo_q);
	end

	// keyword store and length memory
	always_ff @(posedge clk) begin
		if (acc_load && !key_too_long && !table_full)
			store_mem[load_addr] <= s_tdata;
		if (load_stored)
			len_mem[count_q[SLOT_W-1:0]] <= LEN_W'(load_pos_q + POS_W'(1));
		if (cmd.probe)
			len_rd_q <= len_mem[mid[SLOT_W-1:0]];
		if (cmd.fetch)
			key_rd_q <= store_mem[probe_addr];
	end

	// word buffer
	always_ff @(posedge clk) begin
		if (acc_word && (word_len_q < POS_W'(KEY_LEN)))
			wbuf_mem[word_len_q[BIDX_W-1:0]] <= s_tdata;
		if (cmd.fetch)
			word_rd_q <= wbuf_mem[idx_q[BIDX_W-1:0]];
	end

	// keyword table count and load position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			load_pos_q <= '0;
		end else if (acc_clear) begin
			count_q    <= '0;
			load_pos_q <= '0;
		end else if (acc_load) begin
			if (s_tlast)
				load_pos_q <= '0;
			else if (load_pos_q <= POS_W'(KEY_LEN))
				load_pos_q <= load_pos_q + POS_W'(1);
			if (load_stored)
				count_q <= count_q + CNT_W'(1);
		end
	end

	// word length and case flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_len_q    <= '0;
			first_lower_q <= 1'b0;
			first_upper_q <= 1'b0;
			upper_after_q <= 1'b0;
			lower_after_q <= 1'b0;
		end else if (cmd.finish) begin
			word_len_q    <= '0;
			first_lower_q <= 1'b0;
			first_upper_q <= 1'b0;
			upper_after_q <= 1'b0;
			lower_after_q <= 1'b0;
		end else if (acc_word) begin
			if (word_len_q == '0) begin
				first_lower_q <= lower_char(s_tdata);
				first_upper_q <= upper_char(s_tdata);
				upper_after_q <= 1'b0;
				lower_after_q <= 1'b0;
			end else begin
				if (upper_char(s_tdata))
					upper_after_q <= 1'b1;
				if (lower_char(s_tdata))
					lower_after_q <= 1'b1;
			end
			if (word_len_q <= POS_W'(KEY_LEN))
				word_len_q <= word_len_q + POS_W'(1);
		end
	end

	// bisection bounds, probe slot and byte index
	always_ff @(posedge clk) begin
		if (cmd.search_init) begin
			lo_q <= '0;
			hi_q <= count_q;
		end
		if (cmd.narrow_hi)
			hi_q <= probe_q;
		if (cmd.narrow_lo)
			lo_q <= probe_q;
		if (cmd.probe) begin
			probe_q <= mid;
			idx_q   <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_q + LEN_W'(1);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.finish || load_done)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_class_q  <= classify(first_lower_q, first_upper_q, upper_after_q,
				lower_after_q, cmd.match);
			out_status_q <= LOAD_OK;
			out_load_q   <= 1'b0;
		end else if (load_done) begin
			out_class_q  <= CLS_VARIABLE;
			out_status_q <= load_status;
			out_load_q   <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_status_q, out_class_q};
	assign m_tuser  = out_load_q;

endmodule

// ===== sv/identifier_word_classifier.sv =====
// Identifier word classifier: case flags plus bisection lookup in a loaded keyword table.
// Load, clear and non-final word characters are accepted back to back while the output
// register is free; a load end shows its result the cycle after acceptance. A word end
// passes through ST_CLASSIFY and, if a lookup is needed, up to ceil(log2(KEYWORDS))+1
// probes, each ST_PROBE then ST_FETCH/ST_CHECK per byte over one keyword memory port.
// Reset clears table count, load and word state; memories hold contents until written.
module identifier_word_classifier #(
	parameter int KEYWORDS = 64,
	parameter int KEY_LEN  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // char_in
	input  logic       s_tlast,   // last
	input  logic [1:0] s_tuser,   // mode
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // word_class[2:0], load_status[4:3], zero fill
	output logic       m_tuser    // from_load
);
	import iwc_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// controller
	iwc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	iwc_dp #(
		.KEYWORDS (KEYWORDS),
		.KEY_LEN  (KEY_LEN)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
